>>> src/brpc_pkg.sv
// Shared types and constants for the binary relation property checker.
// No dependencies; every other file of the block imports this package.
package brpc_pkg;

    localparam int OP_W      = 2;
    localparam int ELEM_W    = 4;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 9;
    localparam int SETSZ_W   = 5;
    localparam int LIMIT_W   = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVALUATED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED      = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_LIMIT = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [SETSZ_W-1:0] SET_SIZE_RST   = 5'd16;
    localparam logic [LIMIT_W-1:0] PAIR_LIMIT_RST = 9'd256;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ELEM_W-1:0] first_element;
        logic [ELEM_W-1:0] second_element;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  pair_count;
        logic                reflexive;
        logic                symmetric;
        logic                antisymmetric;
        logic                transitive;
        logic                partial_order;
        logic                equivalence;
    } t_out_item;

    // Control of the relation memory.
    typedef struct packed {
        logic clr;
        logic we;
        logic rd_a_en;
        logic rd_b_en;
    } t_mem_ctl;

    // Control of the property accumulator.
    typedef struct packed {
        logic init;
        logic en;
    } t_acc_ctl;

    typedef struct packed {
        logic refl;
        logic sym;
        logic anti;
        logic trans;
    } t_props;

endpackage

>>> src/brpc_in_if.sv
// Input channel of the relation checker: valid/ready handshake with one item.
// Depends on brpc_pkg for the item type.
interface brpc_in_if import brpc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/brpc_out_if.sv
// Result channel of the relation checker: valid/ready handshake with one result.
// Depends on brpc_pkg for the result type.
interface brpc_out_if import brpc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/brpc_rel_mem.sv
// Relation matrix store: one row per element, one write and two read ports.
// Per-row valid bits let reset and clear empty every row at once. Uses brpc_pkg.
module brpc_rel_mem import brpc_pkg::*; #(
    parameter int MAX_SET = 16,
    parameter int AW      = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mem_ctl           i_ctl,
    input  logic [AW-1:0]      i_waddr,
    input  logic [MAX_SET-1:0] i_wdata,
    input  logic [AW-1:0]      i_rd_a_addr,
    input  logic [AW-1:0]      i_rd_b_addr,
    output logic [MAX_SET-1:0] o_rd_a_data,
    output logic [MAX_SET-1:0] o_rd_b_data
);

    logic [MAX_SET-1:0] r_mem [MAX_SET];
    logic [MAX_SET-1:0] r_row_vld;
    logic [MAX_SET-1:0] r_a_data;
    logic [MAX_SET-1:0] r_b_data;
    logic               r_a_vld;
    logic               r_b_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_a_en) begin
            r_a_data <= r_mem[i_rd_a_addr];
        end
        if (i_ctl.rd_b_en) begin
            r_b_data <= r_mem[i_rd_b_addr];
        end
    end

    // A row that was never written since reset or the last clear reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_row_vld <= '0;
            end else if (i_ctl.we) begin
                r_row_vld[i_waddr] <= 1'b1;
            end
            if (i_ctl.rd_a_en) begin
                r_a_vld <= r_row_vld[i_rd_a_addr];
            end
            if (i_ctl.rd_b_en) begin
                r_b_vld <= r_row_vld[i_rd_b_addr];
            end
        end
    end

    assign o_rd_a_data = r_a_vld ? r_a_data : '0;
    assign o_rd_b_data = r_b_vld ? r_b_data : '0;

endmodule

>>> src/brpc_prop_acc.sv
// Property accumulator: folds one (row i, row j) comparison per enabled cycle into the
// reflexive, symmetric, antisymmetric and transitive flags. Uses brpc_pkg.
module brpc_prop_acc import brpc_pkg::*; #(
    parameter int MAX_SET = 16,
    parameter int AW      = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_acc_ctl           i_ctl,
    input  logic [AW-1:0]      i_idx_i,
    input  logic [AW-1:0]      i_idx_j,
    input  logic [MAX_SET-1:0] i_row_i,
    input  logic [MAX_SET-1:0] i_row_j,
    input  logic [MAX_SET-1:0] i_mask,
    output t_props             o_props
);

    t_props r_props;
    logic   ij;
    logic   ji;
    logic   diag;
    logic   trans_miss;

    assign ij         = i_row_i[i_idx_j];
    assign ji         = i_row_j[i_idx_i];
    assign diag       = (i_idx_i == i_idx_j);
    // Row j reaches some element that row i does not.
    assign trans_miss = |(i_row_j & i_mask & ~i_row_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_props <= '1;
        end else if (i_ctl.init) begin
            r_props <= '1;
        end else if (i_ctl.en) begin
            if (diag && !ij) begin
                r_props.refl <= 1'b0;
            end
            if (ij != ji) begin
                r_props.sym <= 1'b0;
            end
            if (!diag && ij && ji) begin
                r_props.anti <= 1'b0;
            end
            if (ij && trans_miss) begin
                r_props.trans <= 1'b0;
            end
        end
    end

    assign o_props = r_props;

endmodule

>>> src/binary_relation_property_checker.sv
// Binary relation property checker. The relation is a matrix of MAX_SET rows
// held in a synchronous memory with two read ports. An insert reads the row,
// tests and writes it back, then hands over the result; a clear empties the
// relation and hands over its result. An evaluate reads every ordered pair of
// rows (i,j) within the effective set size in its own cycle through the two
// read ports and compares it in the property accumulator. One item is in work
// at a time; a finished result waits in the output register while the next
// item is taken. Depends on brpc_pkg, brpc_in_if, brpc_out_if, brpc_rel_mem
// and brpc_prop_acc.
module binary_relation_property_checker import brpc_pkg::*; #(
    parameter int MAX_SET = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    brpc_in_if.sink              i_in,
    brpc_out_if.source           o_out
);

    localparam int AW    = $clog2(MAX_SET);
    localparam int NW    = $clog2(MAX_SET + 1);
    localparam int NN_W  = 2 * NW;
    localparam int LW    = (NN_W > COUNT_W) ? NN_W : COUNT_W;
    localparam int CMP_W = (NW > ELEM_W) ? NW : ELEM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_EVAL,
        S_EVWAIT,
        S_EVFIN,
        S_RESP
    } t_state;

    t_state               r_state;
    logic [SETSZ_W-1:0]   r_set_size;
    logic [LIMIT_W-1:0]   r_pair_limit;
    logic [COUNT_W-1:0]   r_cnt;
    logic [ELEM_W-1:0]    r_a;
    logic [ELEM_W-1:0]    r_b;
    logic [AW-1:0]        r_i;
    logic [AW-1:0]        r_j;
    logic [AW-1:0]        r_chk_i;
    logic [AW-1:0]        r_chk_j;
    logic                 r_chk_v;
    t_out_item            r_res;
    t_out_item            r_out;
    logic                 r_out_v;

    logic                 in_xfer;
    logic [NW-1:0]        n_eff;
    logic [NN_W-1:0]      nn;
    logic [MAX_SET-1:0]   mask;
    logic [MAX_SET-1:0]   row_a;
    logic [MAX_SET-1:0]   row_b;
    logic [MAX_SET-1:0]   bit_b;
    logic                 out_range;
    logic                 dup;
    logic                 at_limit;
    logic                 last_i;
    logic                 last_j;
    logic                 out_free;
    t_mem_ctl             mem_ctl;
    t_acc_ctl             acc_ctl;
    t_props               props;
    logic [AW-1:0]        rd_a_addr;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_out_v || o_out.ready;

    // Effective set size, saturated into 1 .. MAX_SET.
    always_comb begin
        if (r_set_size == '0) begin
            n_eff = NW'(1);
        end else if (int'(r_set_size) > MAX_SET) begin
            n_eff = NW'(MAX_SET);
        end else begin
            n_eff = NW'(r_set_size);
        end
    end

    assign nn = NN_W'(n_eff) * NN_W'(n_eff);

    always_comb begin
        for (int k = 0; k < MAX_SET; k++) begin
            mask[k] = (k < int'(n_eff));
        end
    end

    // Insert decision, made on the row read during the transfer cycle.
    assign out_range = (CMP_W'(r_a) >= CMP_W'(n_eff)) || (CMP_W'(r_b) >= CMP_W'(n_eff));
    assign bit_b     = {{(MAX_SET-1){1'b0}}, 1'b1} << AW'(r_b);
    assign dup       = |(row_a & bit_b);
    assign at_limit  = (LW'(r_cnt) >= LW'(r_pair_limit)) || (LW'(r_cnt) >= LW'(nn));

    assign last_i = (NW'(r_i) == n_eff - NW'(1));
    assign last_j = (NW'(r_j) == n_eff - NW'(1));

    assign rd_a_addr = (r_state == S_IDLE) ? AW'(i_in.payload.first_element) : r_i;

    // The insert writes its row back before the next read is issued, so no
    // forwarding path is needed.
    always_comb begin
        mem_ctl.clr     = in_xfer && (i_in.payload.operation == OP_CLEAR);
        mem_ctl.we      = (r_state == S_INS) && !out_range && !dup && !at_limit;
        mem_ctl.rd_a_en = (in_xfer && (i_in.payload.operation == OP_INSERT))
                          || (r_state == S_EVAL);
        mem_ctl.rd_b_en = (r_state == S_EVAL);
        acc_ctl.init    = in_xfer;
        acc_ctl.en      = r_chk_v;
    end

    brpc_rel_mem #(
        .MAX_SET (MAX_SET),
        .AW      (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mem_ctl),
        .i_waddr     (AW'(r_a)),
        .i_wdata     (row_a | bit_b),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (r_j),
        .o_rd_a_data (row_a),
        .o_rd_b_data (row_b)
    );

    brpc_prop_acc #(
        .MAX_SET (MAX_SET),
        .AW      (AW)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_idx_i (r_chk_i),
        .i_idx_j (r_chk_j),
        .i_row_i (row_a),
        .i_row_j (row_b),
        .i_mask  (mask),
        .o_props (props)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_set_size   <= SET_SIZE_RST;
            r_pair_limit <= PAIR_LIMIT_RST;
            r_cnt        <= '0;
            r_chk_v      <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SET_SIZE:   r_set_size   <= i_cfg_wdata[SETSZ_W-1:0];
                    REG_PAIR_LIMIT: r_pair_limit <= i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (o_out.ready) begin
                r_out_v <= 1'b0;
            end

            r_chk_v <= (r_state == S_EVAL);
            r_chk_i <= r_i;
            r_chk_j <= r_j;

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_a <= i_in.payload.first_element;
                        r_b <= i_in.payload.second_element;
                        r_i <= '0;
                        r_j <= '0;
                        if (i_in.payload.operation == OP_INSERT) begin
                            r_state <= S_INS;
                        end else if (i_in.payload.operation == OP_CLEAR) begin
                            r_cnt            <= '0;
                            r_res            <= '0;
                            r_res.status     <= ST_CLEARED;
                            r_res.pair_count <= '0;
                            r_state          <= S_RESP;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_INS: begin
                    r_res <= '0;
                    if (out_range) begin
                        r_res.status     <= ST_OUT_OF_RANGE;
                        r_res.pair_count <= r_cnt;
                    end else if (dup) begin
                        r_res.status     <= ST_DUPLICATE;
                        r_res.pair_count <= r_cnt;
                    end else if (at_limit) begin
                        r_res.status     <= ST_LIMIT;
                        r_res.pair_count <= r_cnt;
                    end else begin
                        r_cnt            <= r_cnt + COUNT_W'(1);
                        r_res.status     <= ST_ACCEPTED;
                        r_res.pair_count <= r_cnt + COUNT_W'(1);
                    end
                    r_state <= S_RESP;
                end
                S_EVAL: begin
                    if (last_j) begin
                        r_j <= '0;
                        if (last_i) begin
                            r_state <= S_EVWAIT;
                        end else begin
                            r_i <= r_i + AW'(1);
                        end
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_EVWAIT: begin
                    // The last row pair is folded into the flags this cycle.
                    r_state <= S_EVFIN;
                end
                S_EVFIN: begin
                    r_res.status        <= ST_EVALUATED;
                    r_res.pair_count    <= r_cnt;
                    r_res.reflexive     <= props.refl;
                    r_res.symmetric     <= props.sym;
                    r_res.antisymmetric <= props.anti;
                    r_res.transitive    <= props.trans;
                    r_res.partial_order <= props.refl && props.anti && props.trans;
                    r_res.equivalence   <= props.refl && props.sym && props.trans;
                    r_state             <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

endmodule

>>> src/brpc_chk.sv
// Port-level checks for the relation checker, attached to the top level by bind.
// Depends on brpc_pkg and binary_relation_property_checker.
module brpc_chk import brpc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_payload
);

    // A result waiting for the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    // The block works on one item at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // Property flags are only reported on an evaluation.
    a_flags_eval_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_payload.status != ST_EVALUATED) |->
        !(i_out_payload.reflexive || i_out_payload.symmetric
          || i_out_payload.antisymmetric || i_out_payload.transitive
          || i_out_payload.partial_order || i_out_payload.equivalence))
        else $error("property flag set on a non-evaluate result");

    // Derived orders follow from the four basic properties.
    a_derived: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
        (i_out_payload.partial_order == (i_out_payload.reflexive
            && i_out_payload.antisymmetric && i_out_payload.transitive))
        && (i_out_payload.equivalence == (i_out_payload.reflexive
            && i_out_payload.symmetric && i_out_payload.transitive)))
        else $error("partial order or equivalence flag inconsistent");

    // A clear always reports an empty relation.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_payload.status == ST_CLEARED) |->
        (i_out_payload.pair_count == '0))
        else $error("clear reported a nonzero pair count");

endmodule

bind binary_relation_property_checker brpc_chk u_brpc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

>>> bench/tb_top.sv
// Self-checking testbench for binary_relation_property_checker.
// Depends on brpc_pkg, brpc_in_if, brpc_out_if and the block itself; a built-in
// relation predictor computes every expected result and the monitor compares them.
module tb_top import brpc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SET = 16;
    localparam int NUM_PHASES = 14;
    // Operation three is decoded as an evaluate.
    localparam logic [OP_W-1:0] OP_EVAL_ALT = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    brpc_in_if  in_ch ();
    brpc_out_if out_ch ();

    binary_relation_property_checker #(.MAX_SET(MAX_SET)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state: relation matrix, pair count and the two registers.
    logic [MAX_SET-1:0] rel_rows [MAX_SET];
    logic [COUNT_W-1:0] held_cnt;
    logic [SETSZ_W-1:0] set_size_r;
    logic [LIMIT_W-1:0] limit_r;

    t_in_item  item_q [$];
    t_out_item outcome_q [$];
    int        n_queued;
    int        n_done;
    int        mismatch_cnt;
    int        results_seen;
    int        hold_left;
    bit        hold_done;
    bit        no_idle;

    int phase_size  [NUM_PHASES] = '{4, 2, 0, 31, 16, 3, 5, 1, 4, 8, 17, 6, 3, 2};
    int phase_limit [NUM_PHASES] = '{256, 3, 1, 511, 0, 9, 12, 256, 10, 64, 300, 256, 511, 0};

    function automatic int eff_size();
        int n;
        n = set_size_r;
        if (n < 1) n = 1;
        if (n > MAX_SET) n = MAX_SET;
        return n;
    endfunction

    function automatic t_out_item relation_outcome(t_in_item it);
        t_out_item          r;
        int                 n;
        int                 lim;
        logic [MAX_SET-1:0] m;
        logic [MAX_SET-1:0] row;
        logic               ij;
        logic               ji;
        logic               refl;
        logic               sym;
        logic               anti;
        logic               trans;
        n = eff_size();
        r = '0;
        refl = 1'b0;
        sym = 1'b0;
        anti = 1'b0;
        trans = 1'b0;
        if (it.operation == OP_INSERT) begin
            lim = limit_r;
            if (lim > n * n) lim = n * n;
            if (int'(it.first_element) >= n || int'(it.second_element) >= n) begin
                r.status = ST_OUT_OF_RANGE;
            end else if (rel_rows[it.first_element][it.second_element]) begin
                r.status = ST_DUPLICATE;
            end else if (int'(held_cnt) >= lim) begin
                r.status = ST_LIMIT;
            end else begin
                rel_rows[it.first_element][it.second_element] = 1'b1;
                held_cnt = held_cnt + 1'b1;
                r.status = ST_ACCEPTED;
            end
        end else if (it.operation == OP_CLEAR) begin
            for (int k = 0; k < MAX_SET; k++) rel_rows[k] = '0;
            held_cnt = '0;
            r.status = ST_CLEARED;
        end else begin
            m = (n >= MAX_SET) ? '1 : ((MAX_SET'(1) << n) - 1'b1);
            refl = 1'b1;
            sym = 1'b1;
            anti = 1'b1;
            trans = 1'b1;
            for (int i = 0; i < n; i++) begin
                row = rel_rows[i] & m;
                if (!rel_rows[i][i]) refl = 1'b0;
                for (int j = 0; j < n; j++) begin
                    ij = rel_rows[i][j];
                    ji = rel_rows[j][i];
                    if (ij != ji) sym = 1'b0;
                    if (i != j && ij && ji) anti = 1'b0;
                    if (ij && (((rel_rows[j] & m) & ~row) != '0)) trans = 1'b0;
                end
            end
            r.status = ST_EVALUATED;
        end
        r.pair_count    = held_cnt;
        r.reflexive     = refl;
        r.symmetric     = sym;
        r.antisymmetric = anti;
        r.transitive    = trans;
        r.partial_order = refl & anti & trans;
        r.equivalence   = refl & sym & trans;
        return r;
    endfunction

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
            mismatch_cnt++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: once valid is raised it stays up until the transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) outcome_q.push_back(relation_outcome(in_ch.payload));
            if (!in_ch.valid || in_ch.ready) begin
                if (item_q.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
                    in_ch.payload <= item_q.pop_front();
                    in_ch.valid   <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transfer and randomly stalls the result side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                n_done++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: result expected none actual status %0d", $time,
                             out_ch.payload.status);
                    mismatch_cnt++;
                end else begin
                    t_out_item want;
                    want = outcome_q.pop_front();
                    check_field("status", want.status, out_ch.payload.status);
                    check_field("pair_count", want.pair_count, out_ch.payload.pair_count);
                    check_field("reflexive", want.reflexive, out_ch.payload.reflexive);
                    check_field("symmetric", want.symmetric, out_ch.payload.symmetric);
                    check_field("antisymmetric", want.antisymmetric,
                                out_ch.payload.antisymmetric);
                    check_field("transitive", want.transitive, out_ch.payload.transitive);
                    check_field("partial_order", want.partial_order,
                                out_ch.payload.partial_order);
                    check_field("equivalence", want.equivalence, out_ch.payload.equivalence);
                end
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= 600) begin
                hold_done = 1'b1;
                hold_left = 300;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_idle || ($urandom_range(99) >= 37);
            end
        end
    end

    task automatic push_item(logic [OP_W-1:0] op, int a, int b);
        t_in_item it;
        it.operation      = op;
        it.first_element  = ELEM_W'(a);
        it.second_element = ELEM_W'(b);
        item_q.push_back(it);
        n_queued++;
    endtask

    task automatic wait_idle();
        while (n_done < n_queued) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        if (idx == REG_SET_SIZE) set_size_r = data[SETSZ_W-1:0];
        else limit_r = data[LIMIT_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_eval();
        push_item($urandom_range(1) ? OP_EVAL : OP_EVAL_ALT, $urandom_range(15),
                  $urandom_range(15));
    endtask

    // Builds an equivalence from a random partition, sometimes with one pair missing.
    task automatic add_equivalence(int n);
        int lbl [MAX_SET];
        int skip;
        for (int k = 0; k < n; k++) lbl[k] = $urandom_range(2);
        skip = ($urandom_range(5) == 0) ? $urandom_range(n * n - 1) : -1;
        push_item(OP_CLEAR, $urandom_range(15), $urandom_range(15));
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++)
                if (lbl[a] == lbl[b] && a * n + b != skip) push_item(OP_INSERT, a, b);
        random_eval();
    endtask

    // Builds a partial order from random ranks, sometimes disturbed by one extra pair.
    task automatic add_order(int n);
        int rank [MAX_SET];
        for (int k = 0; k < n; k++) rank[k] = $urandom_range(3);
        push_item(OP_CLEAR, $urandom_range(15), $urandom_range(15));
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++)
                if (a == b || rank[a] < rank[b]) push_item(OP_INSERT, a, b);
        if ($urandom_range(3) == 0) push_item(OP_INSERT, $urandom_range(n - 1),
                                              $urandom_range(n - 1));
        random_eval();
        if ($urandom_range(1)) begin
            push_item(OP_INSERT, $urandom_range(n - 1), $urandom_range(n - 1));
            random_eval();
        end
    endtask

    task automatic add_mixed(int n);
        int pick;
        pick = $urandom_range(99);
        if (pick < 62) push_item(OP_INSERT, $urandom_range(n - 1), $urandom_range(n - 1));
        else if (pick < 77) push_item(OP_INSERT, $urandom_range(15), $urandom_range(15));
        else if (pick < 95) random_eval();
        else push_item(OP_CLEAR, $urandom_range(15), $urandom_range(15));
    endtask

    initial begin
        int n;
        int target;
        int pick;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_wdata     = '0;
        i_rst_n       = 1'b0;
        n_queued      = 0;
        n_done        = 0;
        mismatch_cnt  = 0;
        results_seen  = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        no_idle       = 1'b0;
        for (int k = 0; k < MAX_SET; k++) rel_rows[k] = '0;
        held_cnt   = '0;
        set_size_r = SET_SIZE_RST;
        limit_r    = PAIR_LIMIT_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: empty relation, extremes, duplicates.
        random_eval();
        push_item(OP_INSERT, 0, 0);
        push_item(OP_INSERT, 0, 0);
        push_item(OP_INSERT, 15, 15);
        push_item(OP_INSERT, 0, 15);
        push_item(OP_INSERT, 15, 0);
        push_item(OP_EVAL, 0, 0);
        push_item(OP_EVAL_ALT, 15, 15);
        push_item(OP_CLEAR, 15, 15);
        push_item(OP_INSERT, 3, 7);
        push_item(OP_EVAL, 0, 0);
        wait_idle();
        repeat (4) @(posedge i_clk);

        // Shrunk set with a tight limit: check order, stale pair out of range.
        write_reg(REG_SET_SIZE, 9'd3);
        write_reg(REG_PAIR_LIMIT, 9'd2);
        push_item(OP_INSERT, 0, 1);
        push_item(OP_INSERT, 1, 2);
        push_item(OP_INSERT, 0, 1);
        push_item(OP_INSERT, 3, 0);
        push_item(OP_INSERT, 0, 3);
        push_item(OP_INSERT, 3, 7);
        push_item(OP_EVAL, 0, 0);
        push_item(OP_CLEAR, 0, 0);
        push_item(OP_INSERT, 1, 1);
        push_item(OP_EVAL, 0, 0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            repeat (4) @(posedge i_clk);
            write_reg(REG_SET_SIZE, CFG_W'(($urandom_range(15) << SETSZ_W) | phase_size[ph]));
            write_reg(REG_PAIR_LIMIT, CFG_W'(phase_limit[ph]));
            no_idle = (ph == 5);
            n = eff_size();
            target = n_queued + 140;
            while (n_queued < target) begin
                pick = $urandom_range(99);
                if (n <= 8 && pick < 12) add_equivalence(n);
                else if (n <= 8 && pick < 24) add_order(n);
                else add_mixed(n);
            end
        end

        wait_idle();
        repeat (MAX_SET * MAX_SET + 8) @(posedge i_clk);
        if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
